// ===== design/dorc_pkg.sv =====
// shared constants, types and helpers for the candidate ring
package dorc_pkg;

    localparam int MAX_DEPTH    = 256;
    localparam int SCAN_LIMIT   = 16;
    localparam int POP_TRIES    = 4;
    localparam int CAP_LOG2_MAX = $clog2(MAX_DEPTH + 1) - 1;
    localparam int IDX_W        = (CAP_LOG2_MAX > 0) ? CAP_LOG2_MAX : 1;
    localparam int SLOTS        = 1 << IDX_W;
    localparam int CAP_W        = CAP_LOG2_MAX + 1;
    localparam int SCNT_W       = $clog2(SCAN_LIMIT + 1);
    localparam int TRY_W        = $clog2(POP_TRIES + 1);
    localparam int ADDR_W       = 48;
    localparam int SEQ_W        = 32;
    localparam int STAT_W       = 32;
    localparam int NUM_STATS    = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;

    localparam logic [2:0] ST_CONSIDERED = 3'd0;
    localparam logic [2:0] ST_SELECTED   = 3'd1;
    localparam logic [2:0] ST_FILTERED   = 3'd2;
    localparam logic [2:0] ST_UNSAMPLED  = 3'd3;
    localparam logic [2:0] ST_DUPLICATE  = 3'd4;
    localparam logic [2:0] ST_EVICTION   = 3'd5;
    localparam logic [2:0] ST_POPPED     = 3'd6;

    localparam logic [1:0] DEC_SELECTED  = 2'd0;
    localparam logic [1:0] DEC_FILTERED  = 2'd1;
    localparam logic [1:0] DEC_UNSAMPLED = 2'd2;
    localparam logic [1:0] DEC_DUPLICATE = 2'd3;

    localparam logic [1:0] SEL_PREFER = 2'd1;
    localparam logic [1:0] SEL_FILTER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_LOG2   = 2'd1;

    typedef struct packed {
        logic load;
        logic consider;
        logic scan_init;
        logic scan_rd;
        logic scan_step;
        logic dup;
        logic write;
        logic pop_rd;
        logic pop_skip;
        logic pop_take;
        logic attempt_inc;
        logic out_load;
    } dorc_cmd_t;

    typedef struct packed {
        logic is_pop;
        logic addr_zero;
        logic selected;
        logic scan_go;
        logic scan_hit;
        logic pend_zero;
        logic tag_ok;
        logic pend_le;
        logic addr_nz;
        logic last_try;
    } dorc_stat_t;

    function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
                                                  input logic [STAT_W-1:0] b);
        logic [STAT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[STAT_W] ? {STAT_W{1'b1}} : s[STAT_W-1:0];
    endfunction

endpackage

// ===== design/dorc_ctrl.sv =====
// controller state machine for the candidate ring
module dorc_ctrl import dorc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dorc_stat_t sts,
    output dorc_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_CHK      = 8'b0000_0010,
        S_SCAN_RD  = 8'b0000_0100,
        S_SCAN_CMP = 8'b0000_1000,
        S_WR       = 8'b0001_0000,
        S_POP_RD   = 8'b0010_0000,
        S_POP_CMP  = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (sts.is_pop) begin
                    state_next = sts.pend_zero ? S_DONE : S_POP_RD;
                end else if (sts.addr_zero) begin
                    state_next = S_DONE;
                end else begin
                    cmd.consider = 1'b1;
                    if (sts.selected) begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN_RD: begin
                if (sts.scan_go) begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_CMP;
                end else begin
                    state_next = S_WR;
                end
            end
            S_SCAN_CMP: begin
                if (sts.scan_hit) begin
                    cmd.dup    = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_WR: begin
                cmd.write  = 1'b1;
                state_next = S_DONE;
            end
            S_POP_RD: begin
                cmd.pop_rd = 1'b1;
                state_next = S_POP_CMP;
            end
            S_POP_CMP: begin
                if (!sts.tag_ok) begin
                    if (sts.pend_le) begin
                        state_next = S_DONE;
                    end else begin
                        cmd.pop_skip    = 1'b1;
                        cmd.attempt_inc = 1'b1;
                        state_next      = sts.last_try ? S_DONE : S_CHK;
                    end
                end else begin
                    cmd.pop_take = 1'b1;
                    if (sts.addr_nz) begin
                        state_next = S_DONE;
                    end else begin
                        cmd.attempt_inc = 1'b1;
                        state_next      = sts.last_try ? S_DONE : S_CHK;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== design/dorc_dp.sv =====
// datapath: ring memory, sequence numbers, statistics and result registers
module dorc_dp import dorc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_mode,
    input  logic [ADDR_W-1:0]       s_address,
    input  logic                    s_site_match,
    input  logic                    s_sample_hit,
    input  dorc_cmd_t               cmd,
    output dorc_stat_t              sts,
    output logic [1:0]              m_decision,
    output logic                    m_pop_valid,
    output logic [ADDR_W-1:0]       m_pop_address,
    output logic [CAP_W-1:0]        m_pending_count,
    output logic [STAT_W-1:0]       m_considered_count,
    output logic [STAT_W-1:0]       m_selected_count,
    output logic [STAT_W-1:0]       m_filtered_count,
    output logic [STAT_W-1:0]       m_unsampled_count,
    output logic [STAT_W-1:0]       m_duplicate_count,
    output logic [STAT_W-1:0]       m_eviction_count,
    output logic [STAT_W-1:0]       m_popped_count
);

    logic [1:0]        sel_mode_reg;
    logic [3:0]        l2_reg;
    logic              in_pop_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic              in_site_reg, in_hit_reg;
    logic [SEQ_W-1:0]  ws_reg, rs_reg, scan_seq_reg, oldest_reg;
    logic [SCNT_W-1:0] scan_cnt_reg;
    logic [TRY_W-1:0]  attempt_reg;
    logic [STAT_W-1:0] stat_reg [NUM_STATS];
    logic [SLOTS-1:0]  slot_vld_reg;
    logic [ADDR_W-1:0] mem_addr [SLOTS];
    logic [SEQ_W-1:0]  mem_tag [SLOTS];
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [SEQ_W-1:0]  rd_tag_reg;
    logic              rd_vld_reg;
    logic [1:0]        dec_reg;
    logic              pv_reg;
    logic [ADDR_W-1:0] pa_reg;

    logic [1:0]        out_dec_reg;
    logic              out_pv_reg;
    logic [ADDR_W-1:0] out_pa_reg;
    logic [CAP_W-1:0]  out_pend_reg;
    logic [STAT_W-1:0] out_stat_reg [NUM_STATS];

    logic [CAP_W-1:0]  l2_eff;
    logic [CAP_W-1:0]  cap;
    logic [SEQ_W-1:0]  cap32, capm1;
    logic [IDX_W-1:0]  mask;
    logic [SEQ_W-1:0]  pend, ws_inc, rs_inc;
    logic [ADDR_W-1:0] rd_a;
    logic [SEQ_W-1:0]  rd_t;
    logic [IDX_W-1:0]  rd_ix, wr_ix;
    logic              rd_en;
    logic              ring_clr;
    logic              selected;

    assign l2_eff   = (l2_reg > 4'(CAP_LOG2_MAX)) ? CAP_W'(CAP_LOG2_MAX) : CAP_W'(l2_reg);
    assign cap      = CAP_W'(1) << l2_eff;
    assign cap32    = SEQ_W'(cap);
    assign capm1    = cap32 - 32'd1;
    assign mask     = capm1[IDX_W-1:0];
    assign pend     = ws_reg - rs_reg;
    assign ws_inc   = ws_reg + 32'd1;
    assign rs_inc   = rs_reg + 32'd1;
    assign rd_a     = rd_vld_reg ? rd_addr_reg : '0;
    assign rd_t     = rd_vld_reg ? rd_tag_reg : '0;
    assign rd_ix    = cmd.scan_rd ? (scan_seq_reg[IDX_W-1:0] & mask) : (rs_inc[IDX_W-1:0] & mask);
    assign rd_en    = cmd.scan_rd || cmd.pop_rd;
    assign wr_ix    = ws_inc[IDX_W-1:0] & mask;
    assign ring_clr = cfg_we && (cfg_index == CFG_RING_LOG2);

    always_comb begin
        if (sel_mode_reg == SEL_FILTER) begin
            selected = in_site_reg;
        end else begin
            selected = ((sel_mode_reg == SEL_PREFER) && in_site_reg) || in_hit_reg;
        end
    end

    always_comb begin
        sts           = '0;
        sts.is_pop    = in_pop_reg;
        sts.addr_zero = (in_addr_reg == '0);
        sts.selected  = selected;
        sts.scan_go   = (scan_seq_reg > oldest_reg) && (scan_cnt_reg < SCNT_W'(SCAN_LIMIT));
        sts.scan_hit  = (rd_t == scan_seq_reg) && (rd_a == in_addr_reg);
        sts.pend_zero = (pend == '0);
        sts.tag_ok    = (rd_t == rs_inc);
        sts.pend_le   = (pend <= capm1);
        sts.addr_nz   = (rd_a != '0);
        sts.last_try  = (attempt_reg == TRY_W'(POP_TRIES - 1));
    end

    // ring storage
    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            mem_addr[wr_ix] <= in_addr_reg;
            mem_tag[wr_ix]  <= ws_inc;
        end
        if (rd_en) begin
            rd_addr_reg <= mem_addr[rd_ix];
            rd_tag_reg  <= mem_tag[rd_ix];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_mode_reg <= '0;
            l2_reg       <= 4'd4;
            slot_vld_reg <= '0;
            ws_reg       <= '0;
            rs_reg       <= '0;
            rd_vld_reg   <= 1'b0;
            attempt_reg  <= '0;
            scan_cnt_reg <= '0;
            for (int i = 0; i < NUM_STATS; i++) begin
                stat_reg[i] <= '0;
            end
        end else begin
            if (cfg_we && (cfg_index == CFG_SELECT_MODE)) begin
                sel_mode_reg <= cfg_data[1:0];
            end
            if (ring_clr) begin
                l2_reg       <= cfg_data;
                slot_vld_reg <= '0;
                ws_reg       <= '0;
                rs_reg       <= '0;
                for (int i = 0; i < NUM_STATS; i++) begin
                    stat_reg[i] <= '0;
                end
            end
            if (rd_en) begin
                rd_vld_reg <= slot_vld_reg[rd_ix];
            end
            if (cmd.load) begin
                attempt_reg <= '0;
            end
            if (cmd.attempt_inc) begin
                attempt_reg <= attempt_reg + TRY_W'(1);
            end
            if (cmd.scan_init) begin
                scan_cnt_reg <= '0;
            end
            if (cmd.scan_step) begin
                scan_cnt_reg <= scan_cnt_reg + SCNT_W'(1);
            end
            if (cmd.consider) begin
                stat_reg[ST_CONSIDERED] <= sat_add(stat_reg[ST_CONSIDERED], 32'd1);
                if (!selected) begin
                    if (sel_mode_reg == SEL_FILTER) begin
                        stat_reg[ST_FILTERED] <= sat_add(stat_reg[ST_FILTERED], 32'd1);
                    end else begin
                        stat_reg[ST_UNSAMPLED] <= sat_add(stat_reg[ST_UNSAMPLED], 32'd1);
                    end
                end
            end
            if (cmd.dup) begin
                stat_reg[ST_DUPLICATE] <= sat_add(stat_reg[ST_DUPLICATE], 32'd1);
            end
            if (cmd.write) begin
                ws_reg              <= ws_inc;
                slot_vld_reg[wr_ix] <= 1'b1;
                stat_reg[ST_SELECTED] <= sat_add(stat_reg[ST_SELECTED], 32'd1);
                if ((ws_inc - rs_reg) > cap32) begin
                    stat_reg[ST_EVICTION] <= sat_add(stat_reg[ST_EVICTION], 32'd1);
                end
            end
            if (cmd.pop_skip) begin
                stat_reg[ST_EVICTION] <= sat_add(stat_reg[ST_EVICTION], pend - capm1);
                rs_reg                <= ws_reg - capm1;
            end
            if (cmd.pop_take) begin
                rs_reg              <= rs_inc;
                stat_reg[ST_POPPED] <= sat_add(stat_reg[ST_POPPED], 32'd1);
            end
        end
    end

    // per-item working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_pop_reg  <= s_mode;
            in_addr_reg <= s_address;
            in_site_reg <= s_site_match;
            in_hit_reg  <= s_sample_hit;
            dec_reg     <= DEC_SELECTED;
            pv_reg      <= 1'b0;
            pa_reg      <= '0;
        end
        if (!cmd.load && sts.addr_zero && !in_pop_reg) begin
            dec_reg <= DEC_FILTERED;
        end
        if (cmd.consider && !selected) begin
            dec_reg <= (sel_mode_reg == SEL_FILTER) ? DEC_FILTERED : DEC_UNSAMPLED;
        end
        if (cmd.dup) begin
            dec_reg <= DEC_DUPLICATE;
        end
        if (cmd.scan_init) begin
            scan_seq_reg <= ws_reg;
            oldest_reg   <= (ws_reg > cap32) ? (ws_reg - cap32) : '0;
        end
        if (cmd.scan_step) begin
            scan_seq_reg <= scan_seq_reg - 32'd1;
        end
        if (cmd.pop_take && sts.addr_nz) begin
            pv_reg <= 1'b1;
            pa_reg <= rd_a;
        end
    end

    // result beat register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_dec_reg  <= dec_reg;
            out_pv_reg   <= pv_reg;
            out_pa_reg   <= pa_reg;
            out_pend_reg <= (pend > cap32) ? cap : pend[CAP_W-1:0];
            for (int i = 0; i < NUM_STATS; i++) begin
                out_stat_reg[i] <= stat_reg[i];
            end
        end
    end

    assign m_decision         = out_dec_reg;
    assign m_pop_valid        = out_pv_reg;
    assign m_pop_address      = out_pa_reg;
    assign m_pending_count    = out_pend_reg;
    assign m_considered_count = out_stat_reg[ST_CONSIDERED];
    assign m_selected_count   = out_stat_reg[ST_SELECTED];
    assign m_filtered_count   = out_stat_reg[ST_FILTERED];
    assign m_unsampled_count  = out_stat_reg[ST_UNSAMPLED];
    assign m_duplicate_count  = out_stat_reg[ST_DUPLICATE];
    assign m_eviction_count   = out_stat_reg[ST_EVICTION];
    assign m_popped_count     = out_stat_reg[ST_POPPED];

endmodule

// ===== design/dedup_overwrite_candidate_ring.sv =====
// top level: overwriting candidate ring with duplicate filter and statistics
// one beat in flight; consider: dropped before the scan, else scans back over up to 16
// stored entries and ends on a duplicate or stores the address in the ring
// pop: no address when empty, else takes the oldest entry, skipping overwritten ones, at most 4 tries
// a stalled result holds the next beat in its done state until the result is taken
// synchronous active-low reset clears sequences, statistics, slot valid bits,
// sets sample-only mode and ring size 16; no clearing pass is needed
module dedup_overwrite_candidate_ring import dorc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [ADDR_W-1:0]     s_address,
    input  logic                  s_site_match,
    input  logic                  s_sample_hit,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_decision,
    output logic                  m_pop_valid,
    output logic [ADDR_W-1:0]     m_pop_address,
    output logic [CAP_W-1:0]      m_pending_count,
    output logic [STAT_W-1:0]     m_considered_count,
    output logic [STAT_W-1:0]     m_selected_count,
    output logic [STAT_W-1:0]     m_filtered_count,
    output logic [STAT_W-1:0]     m_unsampled_count,
    output logic [STAT_W-1:0]     m_duplicate_count,
    output logic [STAT_W-1:0]     m_eviction_count,
    output logic [STAT_W-1:0]     m_popped_count
);

    dorc_cmd_t  cmd;
    dorc_stat_t sts;

    dorc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dorc_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_mode             (s_mode),
        .s_address          (s_address),
        .s_site_match       (s_site_match),
        .s_sample_hit       (s_sample_hit),
        .cmd                (cmd),
        .sts                (sts),
        .m_decision         (m_decision),
        .m_pop_valid        (m_pop_valid),
        .m_pop_address      (m_pop_address),
        .m_pending_count    (m_pending_count),
        .m_considered_count (m_considered_count),
        .m_selected_count   (m_selected_count),
        .m_filtered_count   (m_filtered_count),
        .m_unsampled_count  (m_unsampled_count),
        .m_duplicate_count  (m_duplicate_count),
        .m_eviction_count   (m_eviction_count),
        .m_popped_count     (m_popped_count)
    );

endmodule

// ===== tb/dedup_overwrite_candidate_ring_test.sv =====
// testbench for the candidate ring: directed and random beats checked against a built-in predictor
module dedup_overwrite_candidate_ring_test;
    import dorc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_CONSIDER = 1'b0;
    localparam logic MODE_POP      = 1'b1;
    localparam logic [1:0] SEL_SAMPLE = 2'd0;
    localparam logic [1:0] SEL_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
    localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};

    typedef struct {
        logic [1:0]        decision;
        logic              pop_valid;
        logic [ADDR_W-1:0] pop_address;
        logic [CAP_W-1:0]  pending;
        logic [STAT_W-1:0] stats [NUM_STATS];
    } ring_result_t;

    class ring_scoreboard;
        logic [ADDR_W-1:0] slot_addr [SLOTS];
        logic [SEQ_W-1:0]  slot_seq [SLOTS];
        logic [SEQ_W-1:0]  wr_seq, rd_seq;
        logic [STAT_W-1:0] stats [NUM_STATS];
        logic [1:0]        sel_mode;
        logic [3:0]        size_log2;
        ring_result_t      pending_results [$];
        int                mismatches;

        function void clear_ring();
            foreach (slot_addr[i]) begin
                slot_addr[i] = '0;
                slot_seq[i] = '0;
            end
            wr_seq = '0;
            rd_seq = '0;
            foreach (stats[i]) stats[i] = '0;
        endfunction

        function void reset();
            clear_ring();
            sel_mode = SEL_SAMPLE;
            size_log2 = 4'd4;
            mismatches = 0;
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_SELECT_MODE) begin
                sel_mode = val[1:0];
            end else if (idx == CFG_RING_LOG2) begin
                size_log2 = val;
                clear_ring();
            end
        endfunction

        function logic [SEQ_W-1:0] ring_cap();
            return (size_log2 >= CAP_LOG2_MAX) ? SEQ_W'(SLOTS) : SEQ_W'(1) << size_log2;
        endfunction

        function void bump(int idx, logic [SEQ_W-1:0] amount);
            logic [STAT_W:0] s;
            s = {1'b0, stats[idx]} + {1'b0, amount};
            stats[idx] = s[STAT_W] ? {STAT_W{1'b1}} : s[STAT_W-1:0];
        endfunction

        function bit already_queued(logic [ADDR_W-1:0] addr, logic [SEQ_W-1:0] c);
            logic [SEQ_W-1:0] oldest, seq;
            int scanned;
            oldest = (wr_seq > c) ? wr_seq - c : '0;
            seq = wr_seq;
            scanned = 0;
            while (seq > oldest && scanned < SCAN_LIMIT) begin
                if (slot_seq[seq & (c - 1)] == seq && slot_addr[seq & (c - 1)] == addr)
                    return 1;
                seq--;
                scanned++;
            end
            return 0;
        endfunction

        function logic [1:0] consider(logic [ADDR_W-1:0] addr, logic site, logic hit,
                                      logic [SEQ_W-1:0] c);
            logic [SEQ_W-1:0] seq;
            if (addr == '0) return DEC_FILTERED;
            bump(ST_CONSIDERED, 1);
            if (sel_mode == SEL_FILTER) begin
                if (!site) begin
                    bump(ST_FILTERED, 1);
                    return DEC_FILTERED;
                end
            end else if (!((sel_mode == SEL_PREFER && site) || hit)) begin
                bump(ST_UNSAMPLED, 1);
                return DEC_UNSAMPLED;
            end
            if (already_queued(addr, c)) begin
                bump(ST_DUPLICATE, 1);
                return DEC_DUPLICATE;
            end
            seq = wr_seq + 1;
            wr_seq = seq;
            if (seq - rd_seq > c) bump(ST_EVICTION, 1);
            slot_addr[seq & (c - 1)] = addr;
            slot_seq[seq & (c - 1)] = seq;
            bump(ST_SELECTED, 1);
            return DEC_SELECTED;
        endfunction

        function bit pop_oldest(output logic [ADDR_W-1:0] addr, input logic [SEQ_W-1:0] c);
            logic [SEQ_W-1:0] pend, seq;
            addr = '0;
            for (int t = 0; t < POP_TRIES; t++) begin
                pend = wr_seq - rd_seq;
                if (pend == 0) return 0;
                seq = rd_seq + 1;
                if (slot_seq[seq & (c - 1)] != seq) begin
                    if (pend <= c - 1) return 0;
                    bump(ST_EVICTION, pend - (c - 1));
                    rd_seq = wr_seq - (c - 1);
                    continue;
                end
                rd_seq = seq;
                bump(ST_POPPED, 1);
                if (slot_addr[seq & (c - 1)] != '0) begin
                    addr = slot_addr[seq & (c - 1)];
                    return 1;
                end
            end
            return 0;
        endfunction

        function void note(logic mode, logic [ADDR_W-1:0] addr, logic site, logic hit);
            ring_result_t r;
            logic [SEQ_W-1:0] c, pend;
            c = ring_cap();
            r.decision = DEC_SELECTED;
            r.pop_valid = 1'b0;
            r.pop_address = '0;
            if (mode == MODE_POP) r.pop_valid = pop_oldest(r.pop_address, c);
            else r.decision = consider(addr, site, hit, c);
            pend = wr_seq - rd_seq;
            if (pend > c) pend = c;
            r.pending = pend[CAP_W-1:0];
            r.stats = stats;
            pending_results.push_back(r);
        endfunction

        function void compare(string field, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %s: expected %0h actual %0h", field, e, a);
            end
        endfunction

        function void check(ring_result_t a);
            ring_result_t e;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result beat with nothing expected");
                return;
            end
            e = pending_results.pop_front();
            compare("decision", e.decision, a.decision);
            compare("pop_valid", e.pop_valid, a.pop_valid);
            compare("pop_address", e.pop_address, a.pop_address);
            compare("pending_count", e.pending, a.pending);
            for (int i = 0; i < NUM_STATS; i++)
                compare($sformatf("stat%0d", i), e.stats[i], a.stats[i]);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_mode = 1'b0;
    logic [ADDR_W-1:0]     s_address = '0;
    logic                  s_site_match = 1'b0;
    logic                  s_sample_hit = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [1:0]            m_decision;
    logic                  m_pop_valid;
    logic [ADDR_W-1:0]     m_pop_address;
    logic [CAP_W-1:0]      m_pending_count;
    logic [STAT_W-1:0]     m_considered_count, m_selected_count, m_filtered_count;
    logic [STAT_W-1:0]     m_unsampled_count, m_duplicate_count, m_eviction_count;
    logic [STAT_W-1:0]     m_popped_count;

    ring_scoreboard ring_sb = new();
    int  burst_left = 0;
    bit  stalls_on = 1'b1;
    int  stall_cnt = 0;
    logic [ADDR_W-1:0] addr_pool [24];

    dedup_overwrite_candidate_ring dut (.*);

    always #4 aclk = ~aclk;

    // receiver: runs of ready broken by stalls of random length while stalls are on, else always ready
    always @(posedge aclk) begin
        ring_result_t r;
        if (aresetn && m_valid && m_ready) begin
            r.decision = m_decision;
            r.pop_valid = m_pop_valid;
            r.pop_address = m_pop_address;
            r.pending = m_pending_count;
            r.stats = '{m_considered_count, m_selected_count, m_filtered_count,
                        m_unsampled_count, m_duplicate_count, m_eviction_count,
                        m_popped_count};
            ring_sb.check(r);
        end
        if (!stalls_on) begin
            m_ready <= 1'b1;
        end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_cnt <= $urandom_range(1, 8);
        end
    end

    task automatic send_beat(logic mode, logic [ADDR_W-1:0] addr, logic site, logic hit);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_address <= addr;
        s_site_match <= site;
        s_sample_hit <= hit;
        do @(posedge aclk); while (!s_ready);
        ring_sb.note(mode, addr, site, hit);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(0, 10);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (ring_sb.pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        ring_sb.configure(idx, val);
        @(posedge aclk);
    endtask

    task automatic random_beat();
        int pick;
        logic [ADDR_W-1:0] a;
        pick = $urandom_range(0, 99);
        a = addr_pool[$urandom_range(0, 23)];
        if (pick < 4) a = '0;
        else if (pick < 14) a = {$urandom, $urandom} & ADDR_ONES;
        if (pick >= 72) send_beat(MODE_POP, {$urandom, $urandom} & ADDR_ONES,
                                  $urandom_range(0, 1), $urandom_range(0, 1));
        else send_beat(MODE_CONSIDER, a, $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    initial begin
        logic [1:0] sel_list [7] = '{SEL_SPARE, SEL_FILTER, SEL_PREFER, SEL_SAMPLE,
                                     SEL_PREFER, SEL_FILTER, SEL_SAMPLE};
        logic [3:0] log2_list [7] = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd2, 4'd4, 4'd3};
        ring_sb.reset();
        foreach (addr_pool[i]) addr_pool[i] = {$urandom, $urandom} & ADDR_ONES;
        addr_pool[0] = 48'd1;
        addr_pool[1] = ADDR_ONES;
        addr_pool[2] = 48'h8000_0000_0000;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed beats at reset settings
        send_beat(MODE_POP, '0, 1'b0, 1'b0);
        send_beat(MODE_CONSIDER, '0, 1'b1, 1'b1);
        send_beat(MODE_CONSIDER, ADDR_ONES, 1'b0, 1'b1);
        send_beat(MODE_CONSIDER, ADDR_ONES, 1'b1, 1'b1);
        send_beat(MODE_CONSIDER, 48'd1, 1'b1, 1'b0);
        send_beat(MODE_CONSIDER, 48'd1, 1'b0, 1'b1);
        for (int i = 2; i < 22; i++) send_beat(MODE_CONSIDER, addr_pool[i], 1'b0, 1'b1);
        send_beat(MODE_POP, ADDR_ONES, 1'b1, 1'b1);
        send_beat(MODE_POP, '0, 1'b0, 1'b0);
        drain();
        write_reg(CFG_SPARE, 4'hF);

        for (int p = 0; p < 7; p++) begin
            write_reg(CFG_RING_LOG2, log2_list[p]);
            write_reg(CFG_SELECT_MODE, {2'b00, sel_list[p]});
            stalls_on = (p != 3);
            repeat (200) random_beat();
            drain();
        end

        if (ring_sb.mismatches == 0 && ring_sb.pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("simulation failed");
        $finish;
    end

endmodule
